[hw/rtl/bresenham_line_rasterizer_top_defines.svh]
// Assertion macros for the line rasterizer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define BLR_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("blr check failed");
// next-cycle implication, disabled while reset is asserted
`define BLR_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("blr check failed");
`else
`define BLR_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons)
`define BLR_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

[hw/rtl/blr_pkg.sv]
// Shared types and constants for the line rasterizer.
// No dependencies.
package blr_pkg;

	localparam int COLOR_BITS = 24;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

endpackage

[hw/rtl/bresenham_line_rasterizer_top.sv]
// Bresenham line rasterizer, pixel-pull stream interface.
// Depends on blr_pkg and bresenham_line_rasterizer_top_defines.svh.
//
// Usage:
//   Slave side (s_*): one command word per handshake. s_tuser[0] is the
//   command: start loads both endpoints and the color from s_tdata and
//   returns the start pixel; step returns the next pixel of the line.
//   Master side (m_*): one result word per command. m_tuser[0] is valid_res,
//   low for a step given while no line is active (coordinates, color and
//   tlast are then zero). m_tlast marks the line's end point.
//   A command taken at a clock edge goes to the input register, then to the
//   result register, which drives m_tvalid.
//   Throughput: one command per clock while m_tready is high; the walk state
//   updates in one pass between registers, so back-to-back steps need no gap.
//   Stall: while m_tready is low the result holds and one more command can
//   sit in the input register; s_tready then drops until the result drains.
//   Reset: arst_n clears both stages and the walk state; no line is active.
`include "bresenham_line_rasterizer_top_defines.svh"

module bresenham_line_rasterizer_top
	import blr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// x_start, y_start, x_end, y_end, pixel_color (low bits first), zero pad
	input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  logic [0:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// pixel_x, pixel_y, out_color (low bits first), zero pad
	output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_tdata,
	// valid_res
	output logic [0:0] m_tuser,
	output logic m_tlast
);

	localparam int CW     = COORD_BITS;
	localparam int DW     = COORD_BITS + 3;
	localparam int OUT_W  = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

	// input stage
	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [CW-1:0]         xs_s1, ys_s1, xe_s1, ye_s1;
	logic [COLOR_BITS-1:0] color_s1;

	// result stage
	logic                  valid_s2;
	logic                  res_valid_s2;
	logic [CW-1:0]         px_s2, py_s2;
	logic [COLOR_BITS-1:0] color_s2;
	logic                  last_s2;

	// walk state
	logic [CW-1:0]         cur_x_q, cur_y_q;
	logic signed [DW-1:0]  decision_q;
	logic [CW-1:0]         remaining_q;
	logic [CW-1:0]         abs_dx_q, abs_dy_q;
	logic                  x_major_q, x_dir_neg_q, y_dir_neg_q;
	logic [COLOR_BITS-1:0] line_color_q;
	logic                  active_q;

	logic advance, fire, s_fire;

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	// next-state and result logic
	logic signed [CW:0]    dx, dy;
	logic [CW-1:0]         adx, ady;
	logic                  st_x_major;
	logic [DW-1:0]         two_adx, two_ady, ini_dec;
	logic [CW-1:0]         st_remaining;
	logic                  dec_nonneg, move_x, move_y;
	logic [DW-1:0]         two_minor, two_major, step_dec;
	logic [CW-1:0]         step_x, step_y, step_remaining;

	logic [CW-1:0]         n_cur_x, n_cur_y, n_remaining, n_adx, n_ady;
	logic signed [DW-1:0]  n_decision;
	logic                  n_x_major, n_x_neg, n_y_neg, n_active;
	logic [COLOR_BITS-1:0] n_color;
	logic                  r_valid, r_last;
	logic [CW-1:0]         r_px, r_py;
	logic [COLOR_BITS-1:0] r_color;

	always_comb begin
		// start-command setup
		dx = signed'({xe_s1[CW-1], xe_s1}) - signed'({xs_s1[CW-1], xs_s1});
		dy = signed'({ye_s1[CW-1], ye_s1}) - signed'({ys_s1[CW-1], ys_s1});
		adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
		ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
		st_x_major = adx > ady;
		two_adx = {2'b00, adx, 1'b0};
		two_ady = {2'b00, ady, 1'b0};
		ini_dec = st_x_major ? (two_ady - {3'b000, adx}) : (two_adx - {3'b000, ady});
		st_remaining = st_x_major ? adx : ady;

		// step-command update
		dec_nonneg = !decision_q[DW-1];
		move_x = x_major_q || dec_nonneg;
		move_y = !x_major_q || dec_nonneg;
		two_minor = x_major_q ? {2'b00, abs_dy_q, 1'b0} : {2'b00, abs_dx_q, 1'b0};
		two_major = x_major_q ? {2'b00, abs_dx_q, 1'b0} : {2'b00, abs_dy_q, 1'b0};
		step_dec = DW'(decision_q) + two_minor - (dec_nonneg ? two_major : DW'(0));
		step_x = !move_x ? cur_x_q :
			(x_dir_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1));
		step_y = !move_y ? cur_y_q :
			(y_dir_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1));
		step_remaining = remaining_q - CW'(1);

		// hold by default
		n_cur_x     = cur_x_q;
		n_cur_y     = cur_y_q;
		n_decision  = decision_q;
		n_remaining = remaining_q;
		n_adx       = abs_dx_q;
		n_ady       = abs_dy_q;
		n_x_major   = x_major_q;
		n_x_neg     = x_dir_neg_q;
		n_y_neg     = y_dir_neg_q;
		n_color     = line_color_q;
		n_active    = active_q;
		r_valid     = 1'b0;
		r_px        = '0;
		r_py        = '0;
		r_color     = '0;
		r_last      = 1'b0;

		case (cmd_s1)
			CMD_START: begin
				n_cur_x     = xs_s1;
				n_cur_y     = ys_s1;
				n_decision  = signed'(ini_dec);
				n_remaining = st_remaining;
				n_adx       = adx;
				n_ady       = ady;
				n_x_major   = st_x_major;
				n_x_neg     = dx[CW];
				n_y_neg     = dy[CW];
				n_color     = color_s1;
				n_active    = st_remaining != '0;
				r_valid     = 1'b1;
				r_px        = xs_s1;
				r_py        = ys_s1;
				r_color     = color_s1;
				r_last      = st_remaining == '0;
			end
			CMD_STEP: begin
				if (active_q) begin
					n_cur_x     = step_x;
					n_cur_y     = step_y;
					n_decision  = signed'(step_dec);
					n_remaining = step_remaining;
					n_active    = step_remaining != '0;
					r_valid     = 1'b1;
					r_px        = step_x;
					r_py        = step_y;
					r_color     = line_color_q;
					r_last      = step_remaining == '0;
				end
			end
			default: begin
				r_valid = 1'b0;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1   <= cmd_t'(s_tuser[0]);
			xs_s1    <= s_tdata[CW-1:0];
			ys_s1    <= s_tdata[2*CW-1:CW];
			xe_s1    <= s_tdata[3*CW-1:2*CW];
			ye_s1    <= s_tdata[4*CW-1:3*CW];
			color_s1 <= s_tdata[4*CW+COLOR_BITS-1:4*CW];
		end
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			decision_q   <= '0;
			remaining_q  <= '0;
			abs_dx_q     <= '0;
			abs_dy_q     <= '0;
			x_major_q    <= 1'b0;
			x_dir_neg_q  <= 1'b0;
			y_dir_neg_q  <= 1'b0;
			line_color_q <= '0;
			active_q     <= 1'b0;
		end else if (fire) begin
			cur_x_q      <= n_cur_x;
			cur_y_q      <= n_cur_y;
			decision_q   <= n_decision;
			remaining_q  <= n_remaining;
			abs_dx_q     <= n_adx;
			abs_dy_q     <= n_ady;
			x_major_q    <= n_x_major;
			x_dir_neg_q  <= n_x_neg;
			y_dir_neg_q  <= n_y_neg;
			line_color_q <= n_color;
			active_q     <= n_active;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_valid_s2 <= r_valid;
			px_s2        <= r_px;
			py_s2        <= r_py;
			color_s2     <= r_color;
			last_s2      <= r_last;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = OUT_W'({color_s2, py_s2, px_s2});
	assign m_tuser[0] = res_valid_s2;
	assign m_tlast    = last_s2;

	// checks
	`BLR_ASSERT_SAME(a_active_has_pixels, clk, arst_n, active_q, remaining_q != '0)
	`BLR_ASSERT_SAME(a_idle_result_blank, clk, arst_n, valid_s2 && !res_valid_s2,
		px_s2 == '0 && py_s2 == '0 && color_s2 == '0 && !last_s2)
	`BLR_ASSERT_NEXT(a_last_ends_line, clk, arst_n, fire && r_valid && r_last, !active_q)
	`BLR_ASSERT_NEXT(a_step_counts_down, clk, arst_n,
		fire && cmd_s1 == CMD_STEP && active_q,
		remaining_q == $past(remaining_q) - CW'(1))

endmodule
